// ===== rtl/block_cache_read_splitter_top_macros.svh =====
// ----------------------------------------------------------------------------
// block cache read splitter assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_READ_SPLITTER_TOP_MACROS_SVH
`define BLOCK_CACHE_READ_SPLITTER_TOP_MACROS_SVH

// same-cycle implication
`define BCRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcrs_pkg
// constants, widths and controller/datapath command and status types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcrs_pkg;

    // tag store geometry and chunk limit
    localparam int CACHE_SLOTS = 256;
    localparam int MAX_CHUNKS  = 64;
    localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int SCNT_W      = $clog2(CACHE_SLOTS + 1) + 1;

    // field widths
    localparam int START_W = 48;
    localparam int COUNT_W = 24;
    localparam int BS_W    = 17;
    localparam int BLK_W   = 32;
    localparam int SLOTO_W = 13;
    localparam int OFF_W   = 16;
    localparam int LEN_W   = 17;

    // block size limits and reset value
    localparam logic [BS_W-1:0] BS_RESET = 17'd512;
    localparam logic [BS_W-1:0] BS_MAX   = 17'd65536;
    localparam logic [BS_W-1:0] BS_MIN   = 17'd1;

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS = START_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // kind of result item to emit
    localparam logic [1:0] RES_NORMAL = 2'd0;
    localparam logic [1:0] RES_ZERO   = 2'd1;
    localparam logic [1:0] RES_ERROR  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       load_chunk;
        logic       prep;
        logic       scan;
        logic       write_tag;
        logic       emit;
        logic [1:0] res_sel;
    } bcrs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic count_zero;
        logic too_many;
        logic match;
        logic scan_end;
        logic last_chunk;
        logic out_free;
    } bcrs_sts_t;

endpackage

// ===== rtl/bcrs_if.sv =====
// ----------------------------------------------------------------------------
// bcrs channel interfaces
// valid/ready channels for read requests and split chunk results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcrs_req_if;
    logic        valid;
    logic        ready;
    logic [47:0] start_byte;
    logic [23:0] byte_count;

    modport source (output valid, output start_byte, output byte_count, input ready);
    modport sink   (input valid, input start_byte, input byte_count, output ready);
endinterface

interface bcrs_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_number;
    logic [12:0] slot;
    logic        hit;
    logic [15:0] offset;
    logic [16:0] chunk_len;
    logic        last;
    logic        status;

    modport source (output valid, output block_number, output slot, output hit,
                    output offset, output chunk_len, output last, output status,
                    input ready);
    modport sink   (input valid, input block_number, input slot, input hit,
                    input offset, input chunk_len, input last, input status,
                    output ready);
endinterface

// ===== rtl/bcrs_ram.sv =====
// ----------------------------------------------------------------------------
// bcrs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bcrs_datapath.sv =====
// ----------------------------------------------------------------------------
// bcrs_datapath
// block size register, serial divider, chunk registers, tag scan, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "block_cache_read_splitter_top_macros.svh"

module bcrs_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bcrs_pkg::BS_W-1:0] cfg_data,
    input  logic [bcrs_pkg::START_W-1:0] start_byte,
    input  logic [bcrs_pkg::COUNT_W-1:0] byte_count,
    input  bcrs_pkg::bcrs_cmd_t       cmd,
    output bcrs_pkg::bcrs_sts_t       sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bcrs_pkg::BLK_W-1:0]   out_block_number,
    output logic [bcrs_pkg::SLOTO_W-1:0] out_slot,
    output logic                      out_hit,
    output logic [bcrs_pkg::OFF_W-1:0]   out_offset,
    output logic [bcrs_pkg::LEN_W-1:0]   out_chunk_len,
    output logic                      out_last,
    output logic                      out_status
);

    import bcrs_pkg::*;

    logic [BS_W-1:0]    bs_reg;
    logic [BS_W-1:0]    bs_eff;
    logic [COUNT_W-1:0] count_reg;
    logic [START_W-1:0] dq_reg;
    logic [OFF_W-1:0]   drem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [BS_W-1:0]    trial;
    logic               trial_ge;
    logic [BLK_W-1:0]   blk_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   room;
    logic [LEN_W-1:0]   len_next;
    logic [31:0]        span;
    logic [31:0]        limit;
    logic [CACHE_SLOTS-1:0] valid_reg;
    logic [SCNT_W-1:0]  rd_cnt_reg;
    logic               rd_en;
    logic               cmp_vld_reg;
    logic [SLOT_W-1:0]  cmp_addr_reg;
    logic [BLK_W-1:0]   tag_rdata;
    logic               have_free_reg;
    logic [SLOT_W-1:0]  free_reg;
    logic [SLOT_W-1:0]  wslot;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic               cmp_valid_bit;
    logic               match_now;

    // block size register, clamped to 1 .. 65536 on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= BS_RESET;
        end
        else if (cfg_we)
        begin
            bs_reg <= cfg_data;
        end
    end

    assign bs_eff = (bs_reg == '0) ? BS_MIN : ((bs_reg > BS_MAX) ? BS_MAX : bs_reg);

    // restoring divider step: start address by block size
    assign trial    = {drem_reg, dq_reg[START_W-1]};
    assign trial_ge = (trial >= bs_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            dcnt_reg <= DCNT_W'(DIV_STEPS);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dq_reg    <= start_byte;
            drem_reg  <= '0;
            count_reg <= byte_count;
        end
        else if (dcnt_reg != '0)
        begin
            dq_reg   <= {dq_reg[START_W-2:0], trial_ge};
            drem_reg <= trial_ge ? OFF_W'(trial - bs_eff) : OFF_W'(trial);
        end
    end

    // request span check against the chunk limit
    assign span  = 32'(drem_reg) + 32'(count_reg);
    assign limit = 32'(bs_eff) * 32'(MAX_CHUNKS);

    // chunk length is the rest of the request or the rest of the block
    assign room     = bs_eff - LEN_W'(off_reg);
    assign len_next = (rem_reg < COUNT_W'(room)) ? LEN_W'(rem_reg) : room;

    // chunk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_chunk)
        begin
            blk_reg <= dq_reg[BLK_W-1:0];
            off_reg <= drem_reg;
            rem_reg <= count_reg;
        end
        else if (cmd.emit && (cmd.res_sel == RES_NORMAL))
        begin
            blk_reg <= blk_reg + 1'b1;
            off_reg <= '0;
            rem_reg <= rem_reg - COUNT_W'(len_reg);
        end
        if (cmd.prep)
        begin
            len_reg <= len_next;
        end
    end

    // tag store
    assign rd_en = cmd.scan && (rd_cnt_reg < SCNT_W'(CACHE_SLOTS));
    assign wslot = have_free_reg ? free_reg : '0;

    bcrs_ram #(
        .WIDTH (BLK_W),
        .DEPTH (CACHE_SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.write_tag),
        .waddr (wslot),
        .wdata (blk_reg),
        .re    (rd_en),
        .raddr (rd_cnt_reg[SLOT_W-1:0]),
        .rdata (tag_rdata)
    );

    // compare stage of the scan
    assign cmp_valid_bit = valid_reg[cmp_addr_reg];
    assign match_now     = cmp_vld_reg && cmp_valid_bit && (tag_rdata == blk_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
            rd_cnt_reg  <= '0;
        end
        else if (cmd.prep)
        begin
            cmp_vld_reg <= 1'b0;
            rd_cnt_reg  <= '0;
        end
        else if (cmd.scan)
        begin
            cmp_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cmp_addr_reg <= rd_cnt_reg[SLOT_W-1:0];
        end
    end

    // first free slot and lookup outcome
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            have_free_reg <= 1'b0;
            free_reg      <= '0;
        end
        else if (cmd.scan && cmp_vld_reg && !cmp_valid_bit && !have_free_reg)
        begin
            have_free_reg <= 1'b1;
            free_reg      <= cmp_addr_reg;
        end
        if (cmd.scan && match_now)
        begin
            slot_reg <= cmp_addr_reg;
            hit_reg  <= 1'b1;
        end
        else if (cmd.write_tag)
        begin
            slot_reg <= wslot;
            hit_reg  <= 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_tag)
        begin
            valid_reg[wslot] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.res_sel)
                RES_NORMAL:
                begin
                    out_block_number <= blk_reg;
                    out_slot         <= SLOTO_W'(slot_reg);
                    out_hit          <= hit_reg;
                    out_offset       <= off_reg;
                    out_chunk_len    <= len_reg;
                    out_last         <= sts.last_chunk;
                    out_status       <= 1'b0;
                end
                RES_ERROR:
                begin
                    out_block_number <= '0;
                    out_slot         <= '0;
                    out_hit          <= 1'b0;
                    out_offset       <= '0;
                    out_chunk_len    <= '0;
                    out_last         <= 1'b1;
                    out_status       <= 1'b1;
                end
                default:
                begin
                    out_block_number <= '0;
                    out_slot         <= '0;
                    out_hit          <= 1'b0;
                    out_offset       <= '0;
                    out_chunk_len    <= '0;
                    out_last         <= 1'b1;
                    out_status       <= 1'b0;
                end
            endcase
        end
    end

    // status to the controller
    always_comb
    begin
        sts.div_done   = (dcnt_reg == '0);
        sts.count_zero = (count_reg == '0);
        sts.too_many   = (span > limit);
        sts.match      = match_now;
        sts.scan_end   = cmp_vld_reg && (cmp_addr_reg == SLOT_W'(CACHE_SLOTS - 1));
        sts.last_chunk = (rem_reg == COUNT_W'(len_reg));
        sts.out_free   = !out_valid || out_ready;
    end

    // checks
    `BCRS_ASSERT_IMP(a_emit_slot_free, cmd.emit, !out_valid || out_ready,
        "result loaded over a pending item")
    `BCRS_ASSERT_IMP(a_fill_target, cmd.write_tag && have_free_reg, !valid_reg[free_reg],
        "fill into a slot that is already valid")
    `BCRS_ASSERT_NXT(a_fill_marks_valid, cmd.write_tag, valid_reg[slot_reg] && !hit_reg,
        "filled slot not marked valid")
    `BCRS_ASSERT_IMP(a_chunk_nonempty, cmd.emit && (cmd.res_sel == RES_NORMAL),
        len_reg != '0, "empty chunk in a normal result")

endmodule

// ===== rtl/bcrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcrs_ctrl
// sequencer for divide, range check, per-chunk tag scan, fill and result issue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bcrs_pkg::bcrs_sts_t sts,
    output bcrs_pkg::bcrs_cmd_t cmd
);

    import bcrs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;

    // state and result kind registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= RES_NORMAL;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.res_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.load_chunk = 1'b1;
                if (sts.count_zero)
                begin
                    sel_next   = RES_ZERO;
                    state_next = S_EMIT;
                end
                else if (sts.too_many)
                begin
                    sel_next   = RES_ERROR;
                    state_next = S_EMIT;
                end
                else
                begin
                    sel_next   = RES_NORMAL;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_tag = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if ((sel_reg != RES_NORMAL) || sts.last_chunk)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/block_cache_read_splitter_top.sv =====
// ----------------------------------------------------------------------------
// block_cache_read_splitter_top
// splits byte read requests into per-block chunks with a tag store lookup
// ----------------------------------------------------------------------------
// usage
//   req carries one read item (start_byte, byte_count); res returns one item
//   per device block touched, the final one flagged by last.
//   cfg_we / cfg_data write the block size (bytes per block, reset 512).
//   write it only while no request is in flight.
// timing
//   a request first runs the serial block divider: 48 quotient bits, one a
//   cycle, then the sequencer sees it done and runs the range check.
//   each chunk then scans the tag store one slot a cycle through the ram read
//   port, over all 256 slots unless an early hit ends the scan.
//   a zero count or an oversized request gives its single item after the
//   range check, with no scan.
// reset
//   clears every valid bit at once and sets the block size to 512.
// stalls
//   a result waits in the output register while the next chunk is scanned;
//   the next result holds until that register is free. a new request is
//   taken while the last item of the previous one waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_cache_read_splitter_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bcrs_pkg::BS_W-1:0] cfg_data,
    bcrs_req_if.sink                  req,
    bcrs_res_if.source                res
);

    import bcrs_pkg::*;

    bcrs_cmd_t cmd;
    bcrs_sts_t sts;
    logic      in_ready;

    assign req.ready = in_ready;

    // sequencer
    bcrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    bcrs_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .start_byte       (req.start_byte),
        .byte_count       (req.byte_count),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .out_block_number (res.block_number),
        .out_slot         (res.slot),
        .out_hit          (res.hit),
        .out_offset       (res.offset),
        .out_chunk_len    (res.chunk_len),
        .out_last         (res.last),
        .out_status       (res.status)
    );

endmodule

// ===== dv/block_cache_read_splitter_top_tb.sv =====
// ----------------------------------------------------------------------------
// block_cache_read_splitter_top_tb
// self-checking bench for the read splitter and its tag store lookup. read
// requests are driven through the valid/ready request channel. each accepted
// request is split into the chunks it should produce, and the tag store is
// tracked alongside. chunk items leaving the block are checked in order,
// field by field. the run steps through several block sizes and idle
// patterns, and it includes a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_cache_read_splitter_top_tb;

    import bcrs_pkg::*;

    // expected content of one chunk item
    typedef struct {
        logic [BLK_W-1:0]   block_number;
        logic [SLOTO_W-1:0] slot;
        logic               hit;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   chunk_len;
        logic               last;
        logic               status;
    } chunk_item_t;

    typedef longint unsigned chunk_fields_t [7];

    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 34;
    localparam int DRAIN_CYCLES = 300;

    // tracks the tag store and holds the chunk items still due from the block
    class chunk_tracker;
        bit [BLK_W-1:0] tags [CACHE_SLOTS];
        bit             tag_valid [CACHE_SLOTS];
        bit [BS_W-1:0]  blk_bytes;
        chunk_item_t    chunks_due [$];
        int             errors;

        function new();
            blk_bytes = BS_RESET;
            errors    = 0;
            foreach (tag_valid[i])
                tag_valid[i] = 1'b0;
        endfunction

        function void write_blk_bytes(bit [BS_W-1:0] v);
            blk_bytes = v;
        endfunction

        // zero behaves as one, anything above the maximum as the maximum
        function longint unsigned effective_bs();
            longint unsigned bs;
            bs = blk_bytes;
            if (bs == 0)
                bs = 1;
            if (bs > BS_MAX)
                bs = BS_MAX;
            return bs;
        endfunction

        function int outstanding();
            return chunks_due.size();
        endfunction

        function void push_chunk(longint unsigned blk, int unsigned slot, bit hit,
                                 longint unsigned off, longint unsigned len,
                                 bit last, bit status);
            chunk_item_t c;
            c.block_number = blk[BLK_W-1:0];
            c.slot         = slot[SLOTO_W-1:0];
            c.hit          = hit;
            c.offset       = off[OFF_W-1:0];
            c.chunk_len    = len[LEN_W-1:0];
            c.last         = last;
            c.status       = status;
            chunks_due.push_back(c);
        endfunction

        // first valid match hits; a miss claims the first free slot, else slot 0
        function int unsigned lookup_tag(bit [BLK_W-1:0] tag, output bit hit);
            int unsigned victim;
            bit          found_free;
            victim     = 0;
            found_free = 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (tag_valid[i] && tags[i] == tag)
                begin
                    hit = 1'b1;
                    return i;
                end
                if (!found_free && !tag_valid[i])
                begin
                    found_free = 1'b1;
                    victim     = i;
                end
            end
            tags[victim]      = tag;
            tag_valid[victim] = 1'b1;
            hit               = 1'b0;
            return victim;
        endfunction

        // split one accepted request into its chunk items
        function void split_request(bit [START_W-1:0] start, bit [COUNT_W-1:0] count);
            longint unsigned bs, s, n, nch, done, addr, blk, off, len;
            int unsigned     slot;
            bit              hit;
            bs = effective_bs();
            s  = start;
            n  = count;
            if (n == 0)
            begin
                push_chunk(0, 0, 1'b0, 0, 0, 1'b1, 1'b0);
                return;
            end
            nch = ((s % bs) + n + bs - 1) / bs;
            if (nch > MAX_CHUNKS)
            begin
                push_chunk(0, 0, 1'b0, 0, 0, 1'b1, 1'b1);
                return;
            end
            done = 0;
            while (done < n)
            begin
                addr = s + done;
                blk  = addr / bs;
                off  = addr % bs;
                len  = n - done;
                if (len > bs - off)
                    len = bs - off;
                slot = lookup_tag(blk[BLK_W-1:0], hit);
                done += len;
                push_chunk(blk, slot, hit, off, len, done >= n, 1'b0);
            end
        endfunction

        function chunk_fields_t to_fields(chunk_item_t c);
            chunk_fields_t f;
            f[0] = c.block_number;
            f[1] = c.slot;
            f[2] = c.hit;
            f[3] = c.offset;
            f[4] = c.chunk_len;
            f[5] = c.last;
            f[6] = c.status;
            return f;
        endfunction

        // compare one chunk item leaving the block with the oldest one due
        function void check_chunk(chunk_item_t got);
            chunk_item_t   want;
            chunk_fields_t fw, fg;
            string         names [7];
            names = '{"block_number", "slot", "hit", "offset", "chunk_len", "last",
                      "status"};
            fg = to_fields(got);
            if (chunks_due.size() == 0)
            begin
                $display("%0t: unexpected chunk item, expected none, got block %0h slot %0h",
                         $time, fg[0], fg[1]);
                errors++;
                return;
            end
            want = chunks_due.pop_front();
            fw   = to_fields(want);
            for (int i = 0; i < 7; i++)
            begin
                if (fw[i] != fg[i])
                begin
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, names[i], fw[i], fg[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [BS_W-1:0] cfg_data;

    bcrs_req_if req_ch ();
    bcrs_res_if res_ch ();

    chunk_tracker     tracker;
    chunk_item_t      seen;
    int               idle_mode;
    int               hold_seq;
    bit [START_W-1:0] hot [8];

    block_cache_read_splitter_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .res      (res_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle patterns: 0 none, 1 sender, 2 receiver, 3 both lightly
    function automatic bit sender_gap();
        case (idle_mode)
            1: return $urandom_range(99) < 67;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            2: return $urandom_range(99) < 67;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit [START_W-1:0] rand_addr();
        return START_W'({$urandom, $urandom});
    endfunction

    // offer one request and wait until it is taken
    task automatic send_req(input bit [START_W-1:0] s, input bit [COUNT_W-1:0] c);
        while (sender_gap())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.start_byte <= s;
        req_ch.byte_count <= c;
        do
            @(posedge clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        tracker.split_request(s, c);
    endtask

    // wait for the block to go idle, then write a new block size
    task automatic set_blk_bytes(input bit [BS_W-1:0] v);
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_blk_bytes(v);
    endtask

    // one random request, mostly near a few hot addresses so that blocks repeat
    task automatic send_random_req();
        longint unsigned  ebs;
        int unsigned      kind, nch;
        bit [START_W-1:0] s;
        bit [COUNT_W-1:0] c;
        ebs  = tracker.effective_bs();
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            s   = hot[$urandom_range(7)] + $urandom_range(32'(4 * ebs));
            nch = ($urandom_range(19) == 0) ? $urandom_range(64, 4) : $urandom_range(3, 1);
            c   = COUNT_W'($urandom_range(32'(nch * ebs), 1));
        end
        else if (kind < 75)
        begin
            s = rand_addr();
            c = COUNT_W'($urandom_range(32'(2 * ebs), 1));
        end
        else if (kind < 85)
        begin
            s = rand_addr();
            c = '0;
        end
        else if (kind < 95)
        begin
            s = rand_addr();
            c = COUNT_W'($urandom);
        end
        else
        begin
            // exactly the chunk limit, or one chunk over it
            s = hot[$urandom_range(7)] + $urandom_range(32'(4 * ebs));
            c = COUNT_W'(MAX_CHUNKS * ebs - (s % ebs) + $urandom_range(1));
        end
        send_req(s, c);
    endtask

    // pick hot addresses for a phase, one aliasing another after truncation
    task automatic pick_hot(input longint unsigned ebs);
        for (int i = 0; i < 4; i++)
            hot[i] = rand_addr();
        hot[4] = '0;
        hot[5] = 48'(ebs * $urandom_range(16));
        hot[6] = 48'(ebs * $urandom);
        hot[7] = hot[0] + (48'(ebs) << 32);
    endtask

    // receiver: random stalls, plus a long hold when the stimulus asks for one
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !receiver_stall();
        end
    end

    // monitor: every accepted chunk item goes to the checker
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                seen.block_number = res_ch.block_number;
                seen.slot         = res_ch.slot;
                seen.hit          = res_ch.hit;
                seen.offset       = res_ch.offset;
                seen.chunk_len    = res_ch.chunk_len;
                seen.last         = res_ch.last;
                seen.status       = res_ch.status;
                tracker.check_chunk(seen);
            end
        end
    end

    // main stimulus
    initial
    begin
        bit [BS_W-1:0] sizes [9];
        tracker           = new();
        idle_mode         = 0;
        hold_seq          = 0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.start_byte = '0;
        req_ch.byte_count = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset block size, zero counts, limits, first miss then hit
        send_req(48'h0, 24'h0);
        send_req(48'hFFFF_FFFF_FFFF, 24'h0);
        send_req(48'h0, 24'h1);
        send_req(48'h0, 24'h1);
        send_req(48'd511, 24'd2);
        send_req(48'h0, 24'd32768);
        send_req(48'h1, 24'd32768);
        send_req(48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
        send_req(48'hFFFF_FFFF_FFFF, 24'h1);
        send_req(48'd100, 24'd1023);

        // zero block size acts as one; high address aliases block 5
        set_blk_bytes(17'd0);
        send_req(48'd5, 24'd3);
        send_req(48'h1_0000_0005, 24'd1);
        send_req(48'd7, 24'd65);

        // largest block size, full-length chunks
        set_blk_bytes(BS_MAX);
        send_req(48'h0, 24'd4194304);
        send_req(48'd65535, 24'd2);

        // oversized block size clamps to the maximum
        set_blk_bytes(17'h1_FFFF);
        send_req(48'h1, 24'd4194304);
        send_req(48'h1234_5678_9ABC, 24'd70000);
        set_blk_bytes(17'd70000);
        send_req(48'd12345, 24'd1);

        // random phases over several block sizes and idle patterns
        sizes = '{17'd512, 17'd1, 17'd4096, BS_MAX, 17'h1_FFFF, 17'd0, 17'd3, 17'd1000,
                  17'($urandom)};
        for (int p = 0; p < 9; p++)
        begin
            set_blk_bytes(sizes[p]);
            idle_mode = p % 4;
            pick_hot(tracker.effective_bs());
            if (p == 2 || p == 6)
                hold_seq <= hold_seq + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random_req();
        end

        // fill every slot, then misses reuse slot 0
        set_blk_bytes(17'd1);
        idle_mode = 0;
        for (int k = 0; k < 5; k++)
            send_req(48'h8000_0000_0000 + k * 64, 24'd64);
        send_req(48'h8000_0000_0000, 24'd3);
        send_req(48'h8000_0000_0000 + 4 * 64 + 63, 24'd1);

        // drain
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #(300_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
